// File: design/virtual_region_tracker_defines.svh
// ----------------------------------------------------------------------------
// Virtual region tracker assertion macros
// Shared concurrent assertion forms for the region tracker RTL.
// ----------------------------------------------------------------------------
`ifndef VIRTUAL_REGION_TRACKER_DEFINES_SVH
`define VIRTUAL_REGION_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VRT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/vrt_pkg.sv
// ----------------------------------------------------------------------------
// Virtual region tracker package
// Operation and status codes, table entry layout and protection translation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vrt_pkg;

	localparam int ADDR_W = 48;
	localparam int PROT_W = 16;

	// operation codes
	localparam logic [2:0] OP_ALLOC    = 3'd0;
	localparam logic [2:0] OP_RELEASE  = 3'd1;
	localparam logic [2:0] OP_DECOMMIT = 3'd2;
	localparam logic [2:0] OP_PROTECT  = 3'd3;
	localparam logic [2:0] OP_QUERY    = 3'd4;

	// status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	// region states
	localparam logic [1:0] RSTATE_FREE    = 2'd0;
	localparam logic [1:0] RSTATE_RESERVE = 2'd1;
	localparam logic [1:0] RSTATE_COMMIT  = 2'd2;

	// page protection codes (low byte)
	localparam logic [7:0] PROT_NOACCESS  = 8'h01;
	localparam logic [7:0] PROT_READONLY  = 8'h02;
	localparam logic [7:0] PROT_READWRITE = 8'h04;
	localparam logic [7:0] PROT_WRITECOPY = 8'h08;
	localparam logic [7:0] PROT_EXECUTE   = 8'h10;
	localparam logic [7:0] PROT_EXEC_READ = 8'h20;
	localparam logic [7:0] PROT_EXEC_RW   = 8'h40;

	localparam logic [PROT_W-1:0] CODE_NOACCESS  = 16'h0001;
	localparam logic [PROT_W-1:0] CODE_READWRITE = 16'h0004;

	// span reported for an address that no region covers
	localparam logic [ADDR_W-1:0] UNTRACKED_SPAN = 48'h0000_0001_0000;

	// host permission bits
	localparam logic [2:0] HOST_NONE = 3'd0;
	localparam logic [2:0] HOST_R    = 3'd1;
	localparam logic [2:0] HOST_RW   = 3'd3;
	localparam logic [2:0] HOST_X    = 3'd4;
	localparam logic [2:0] HOST_RX   = 3'd5;
	localparam logic [2:0] HOST_RWX  = 3'd7;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] size;
		logic              committed;
		logic [PROT_W-1:0] protect;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// per-entry outcome of the shared compare unit
	typedef struct packed {
		logic contains;
		logic vacant;
		logic base_eq;
	} cmp_t;

	function automatic logic [2:0] host_bits(input logic [PROT_W-1:0] code);
		logic [2:0] bits;
		case (code[7:0])
			PROT_NOACCESS:  bits = HOST_NONE;
			PROT_READONLY:  bits = HOST_R;
			PROT_READWRITE: bits = HOST_RW;
			PROT_WRITECOPY: bits = HOST_RW;
			PROT_EXECUTE:   bits = HOST_X;
			PROT_EXEC_READ: bits = HOST_RX;
			PROT_EXEC_RW:   bits = HOST_RWX;
			default:        bits = HOST_RW;
		endcase
		return bits;
	endfunction

endpackage

// File: design/vrt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/vrt_cmp.sv
// ----------------------------------------------------------------------------
// Region entry compare unit
// Classifies one table entry against the lookup key and the release address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrt_cmp (
	input  vrt_pkg::entry_t                 entry,
	input  logic [vrt_pkg::ADDR_W-1:0]      key,
	input  logic [vrt_pkg::ADDR_W-1:0]      addr,
	output vrt_pkg::cmp_t                   flags
);

	logic [vrt_pkg::ADDR_W:0] end_addr;

	// region end may pass the 48-bit space, so keep the carry
	assign end_addr = {1'b0, entry.base} + {1'b0, entry.size};

	assign flags.contains = entry.valid && (key >= entry.base) && ({1'b0, key} < end_addr);
	assign flags.vacant   = !entry.valid;
	assign flags.base_eq  = entry.valid && (entry.base == addr);

endmodule

// File: design/virtual_region_tracker.sv
// Flow: a request that fails its parameter check skips the table pass and goes straight
//   to the result slot; every other request makes one table pass, an entry per cycle
//   through the RAM read port and compare unit, then takes the update and result slots.
//   A new request is refused (s_tready low) until the result of the last one is loaded.
// Reset: arst_n clears control state, then a clearing pass marks every entry free;
//   s_tready stays low until it finishes.
// ----------------------------------------------------------------------------
// Virtual region tracker
// Table of virtual memory regions with alloc, release, decommit, protect and
// query operations, looked up by a sequential scan of the table RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "virtual_region_tracker_defines.svh"

module virtual_region_tracker #(
	parameter int REGIONS    = 2048,
	parameter int PAGE_BYTES = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	// request channel
	input  logic         s_tvalid,
	output logic         s_tready,
	// [47:0] address, [95:48] length, [96] commit, [112:97] new_protect, [119:113] zero
	input  logic [119:0] s_tdata,
	// [2:0] op
	input  logic [2:0]   s_tuser,
	// result channel
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] found, [48:1] region_base, [96:49] region_size, [98:97] region_state,
	// [114:99] region_protect, [130:115] old_protect, [133:131] host_prot,
	// [181:134] used_size, [183:182] zero
	output logic [183:0] m_tdata,
	// [1:0] status
	output logic [1:0]   m_tuser
);

	localparam int AW     = vrt_pkg::ADDR_W;
	localparam int PW     = vrt_pkg::PROT_W;
	localparam int IDX_W  = $clog2(REGIONS);
	localparam int PG_LG  = $clog2(PAGE_BYTES);
	localparam int RND_W  = AW + 1 - PG_LG;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(REGIONS - 1);
	localparam logic [AW-1:0]    PAGE_SIZE = AW'(PAGE_BYTES);

	// sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;

	// request fields
	logic [2:0]    in_op;
	logic [AW-1:0] in_addr;
	logic [AW-1:0] in_len;
	logic          in_commit;
	logic [PW-1:0] in_prot;

	assign in_op     = s_tuser;
	assign in_addr   = s_tdata[47:0];
	assign in_len    = s_tdata[95:48];
	assign in_commit = s_tdata[96];
	assign in_prot   = s_tdata[112:97];

	// page rounding of the requested length; top bit flags overflow past 48 bits
	logic [RND_W-1:0] rnd_pages;
	logic [AW-1:0]    in_pbase;
	logic             in_ovf;
	logic             in_bad;

	assign rnd_pages = {1'b0, in_len[AW-1:PG_LG]} + RND_W'(|in_len[PG_LG-1:0]);
	assign in_ovf    = rnd_pages[RND_W-1];
	assign in_pbase  = {in_addr[AW-1:PG_LG], {PG_LG{1'b0}}};

	// parameter check done at acceptance; a failing request skips the scan
	always_comb begin
		case (in_op)
			vrt_pkg::OP_ALLOC:    in_bad = (in_len == '0) || in_ovf;
			vrt_pkg::OP_RELEASE,
			vrt_pkg::OP_DECOMMIT: in_bad = (in_addr == '0);
			vrt_pkg::OP_PROTECT:  in_bad = (in_addr == '0) || (in_len == '0) || in_ovf;
			vrt_pkg::OP_QUERY:    in_bad = 1'b0;
			default:              in_bad = 1'b1;
		endcase
	end

	// held request
	logic [2:0]    op_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] len_q;
	logic          commit_q;
	logic [PW-1:0] prot_q;
	logic [AW-1:0] pbase_q;
	logic [AW-1:0] key_q;
	logic [AW-1:0] rsize_q;
	logic          bad_q;

	// scan pipeline
	logic             iss_on_q;
	logic [IDX_W-1:0] iss_idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] clr_idx_q;

	// scan outcome
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	vrt_pkg::entry_t  hit_ent_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             rel_q;
	logic [IDX_W-1:0] rel_idx_q;

	// table RAM
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	vrt_pkg::entry_t         wr_ent;
	logic [vrt_pkg::ENTRY_W-1:0] rd_word;
	vrt_pkg::entry_t         rd_ent;
	vrt_pkg::cmp_t           flags;

	logic accept;
	logic out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	vrt_ram #(
		.WIDTH (vrt_pkg::ENTRY_W),
		.DEPTH (REGIONS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_ent),
		.rd_addr (iss_idx_q),
		.rd_data (rd_word)
	);

	assign rd_ent = vrt_pkg::entry_t'(rd_word);

	vrt_cmp u_cmp (
		.entry (rd_ent),
		.key   (key_q),
		.addr  (addr_q),
		.flags (flags)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			iss_on_q  <= 1'b0;
			iss_idx_q <= '0;
			vld_s1    <= 1'b0;
		end else begin
			vld_s1 <= iss_on_q;
			case (state_q)
				ST_CLEAR: begin
					// sweep the table once, marking every entry free
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_bad) begin
							state_q <= ST_DONE;
						end else begin
							state_q   <= ST_SCAN;
							iss_on_q  <= 1'b1;
							iss_idx_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					// issue one read per cycle, stop issuing after the last entry
					if (iss_on_q) begin
						iss_idx_q <= iss_idx_q + 1'b1;
						if (iss_idx_q == LAST_IDX) begin
							iss_on_q <= 1'b0;
						end
					end
					if (vld_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the request and track the entry index in flight
	always_ff @(posedge clk) begin
		idx_s1 <= iss_idx_q;
		if (accept) begin
			op_q     <= in_op;
			addr_q   <= in_addr;
			len_q    <= in_len;
			commit_q <= in_commit;
			prot_q   <= in_prot;
			pbase_q  <= in_pbase;
			key_q    <= (in_op == vrt_pkg::OP_ALLOC) ? in_pbase : in_addr;
			rsize_q  <= {rnd_pages[RND_W-2:0], {PG_LG{1'b0}}};
			bad_q    <= in_bad;
		end
	end

	// record the first containing, first free and first exact-base entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			rel_q  <= 1'b0;
		end else if (accept) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			rel_q  <= 1'b0;
		end else if (state_q == ST_SCAN && vld_s1) begin
			if (!hit_q && flags.contains) begin
				hit_q <= 1'b1;
			end
			if (!free_q && flags.vacant) begin
				free_q <= 1'b1;
			end
			if (!rel_q && flags.base_eq) begin
				rel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && vld_s1) begin
			if (!hit_q && flags.contains) begin
				hit_idx_q <= idx_s1;
				hit_ent_q <= rd_ent;
			end
			if (!free_q && flags.vacant) begin
				free_idx_q <= idx_s1;
			end
			if (!rel_q && flags.base_eq) begin
				rel_idx_q <= idx_s1;
			end
		end
	end

	// table update: clearing pass, or the single write that follows a scan
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hit_idx_q;
		wr_ent  = hit_ent_q;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
			wr_ent  = '0;
		end else if (state_q == ST_WRITE) begin
			case (op_q)
				vrt_pkg::OP_ALLOC: begin
					if (hit_q) begin
						// promote a reserved region to commit
						wr_en                 = !hit_ent_q.committed && commit_q;
						wr_ent.committed = 1'b1;
						wr_ent.protect   = prot_q;
					end else begin
						wr_en            = free_q;
						wr_addr          = free_idx_q;
						wr_ent.valid     = 1'b1;
						wr_ent.base      = pbase_q;
						wr_ent.size      = rsize_q;
						wr_ent.committed = commit_q;
						wr_ent.protect   = prot_q;
					end
				end
				vrt_pkg::OP_RELEASE: begin
					wr_en   = rel_q;
					wr_addr = rel_idx_q;
					wr_ent  = '0;
				end
				vrt_pkg::OP_DECOMMIT: begin
					wr_en            = hit_q;
					wr_ent.committed = 1'b0;
				end
				vrt_pkg::OP_PROTECT: begin
					wr_en          = hit_q;
					wr_ent.protect = prot_q;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// result fields, built from the held request and the scan outcome
	logic [1:0]    res_status;
	logic          res_found;
	logic [AW-1:0] res_base;
	logic [AW-1:0] res_size;
	logic [1:0]    res_state;
	logic [PW-1:0] res_prot;
	logic [PW-1:0] res_old;
	logic [2:0]    res_host;
	logic [AW-1:0] res_used;
	logic [1:0]    hit_state;

	assign hit_state = hit_ent_q.committed ? vrt_pkg::RSTATE_COMMIT : vrt_pkg::RSTATE_RESERVE;

	always_comb begin
		res_status = vrt_pkg::STATUS_OK;
		res_found  = 1'b0;
		res_base   = '0;
		res_size   = '0;
		res_state  = vrt_pkg::RSTATE_FREE;
		res_prot   = '0;
		res_old    = '0;
		res_host   = vrt_pkg::HOST_NONE;
		res_used   = '0;
		if (bad_q) begin
			res_status = vrt_pkg::STATUS_INVALID;
		end else begin
			case (op_q)
				vrt_pkg::OP_ALLOC: begin
					res_status = (!hit_q && !free_q) ? vrt_pkg::STATUS_FULL : vrt_pkg::STATUS_OK;
					res_found  = hit_q;
					res_base   = pbase_q;
					res_size   = rsize_q;
					res_state  = commit_q ? vrt_pkg::RSTATE_COMMIT : vrt_pkg::RSTATE_RESERVE;
					res_prot   = prot_q;
					res_host   = commit_q ? vrt_pkg::host_bits(prot_q) : vrt_pkg::HOST_NONE;
					res_used   = rsize_q;
				end
				vrt_pkg::OP_RELEASE,
				vrt_pkg::OP_DECOMMIT,
				vrt_pkg::OP_PROTECT: begin
					if (hit_q) begin
						res_found = 1'b1;
						res_base  = hit_ent_q.base;
						res_size  = hit_ent_q.size;
						res_state = hit_state;
						res_prot  = hit_ent_q.protect;
					end
					if (op_q == vrt_pkg::OP_RELEASE) begin
						if (len_q != '0) begin
							res_used = len_q;
						end else begin
							res_used = hit_q ? hit_ent_q.size : PAGE_SIZE;
						end
					end else if (op_q == vrt_pkg::OP_DECOMMIT) begin
						res_used = (len_q != '0) ? len_q : PAGE_SIZE;
					end else begin
						res_old  = hit_q ? hit_ent_q.protect : vrt_pkg::CODE_READWRITE;
						res_host = vrt_pkg::host_bits(prot_q);
						res_used = rsize_q;
					end
				end
				vrt_pkg::OP_QUERY: begin
					if (hit_q) begin
						res_found = 1'b1;
						res_base  = hit_ent_q.base;
						res_size  = hit_ent_q.size;
						res_state = hit_state;
						res_prot  = hit_ent_q.protect;
						res_host  = hit_ent_q.committed ? vrt_pkg::host_bits(hit_ent_q.protect)
							: vrt_pkg::HOST_NONE;
						res_used  = hit_ent_q.size;
					end else begin
						// untracked: report a free span at the page base
						res_base = pbase_q;
						res_size = vrt_pkg::UNTRACKED_SPAN;
						res_prot = vrt_pkg::CODE_NOACCESS;
						res_used = vrt_pkg::UNTRACKED_SPAN;
					end
				end
				default: begin
					res_status = vrt_pkg::STATUS_INVALID;
				end
			endcase
		end
	end

	// output register: load when the sequencer finishes and the slot is free
	logic         m_tvalid_q;
	logic [183:0] m_tdata_q;
	logic [1:0]   m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tuser_q <= res_status;
			m_tdata_q <= {2'b00, res_used, res_host, res_old, res_prot, res_state,
				res_size, res_base, res_found};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// the table is never written while a scan reads it
	`VRT_ASSERT_IMPL(a_no_write_in_scan, clk, arst_n, state_q == ST_SCAN, !wr_en,
		"table written during scan")

	// requests are refused until the clearing pass has finished
	`VRT_ASSERT_IMPL(a_no_accept_in_clear, clk, arst_n, state_q == ST_CLEAR, !s_tready,
		"request accepted during clearing pass")

	// the update slot always advances to the result slot in the next cycle
	`VRT_ASSERT_NEXT(a_write_one_cycle, clk, arst_n, state_q == ST_WRITE, state_q == ST_DONE,
		"update slot did not advance to result")

	// a recorded containing entry always came from a valid slot
	`VRT_ASSERT_IMPL(a_hit_is_valid, clk, arst_n, hit_q && state_q == ST_WRITE, hit_ent_q.valid,
		"containing entry captured from a free slot")

endmodule
